// ===== hdl/msq_pkg.sv =====
package msq_pkg;
   localparam int MAX_POINTS_DEF = 256;
   localparam int COORD_BITS_DEF = 16;
   localparam int AREA_BITS = 33;
endpackage

// ===== hdl/msq_ram.sv =====
module msq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/msq_front.sv =====
// Loads points into three store copies; hands a search job (point count) to the back end.
module msq_front #(
   parameter int MAX_POINTS = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [COORD_BITS-1:0]      req_coord_x,
   input  logic [COORD_BITS-1:0]      req_coord_y,
   input  logic                       req_last_point,
   output logic                       wr_en,
   output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   output logic [2*COORD_BITS-1:0]    wr_data,
   output logic                       job_valid,
   output logic [$clog2(MAX_POINTS):0] job_count,
   input  logic                       job_done
);
   localparam int CW = $clog2(MAX_POINTS) + 1;
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          acc;

   // store is shared with the back end, so loading waits while a search runs
   assign req_stall = busy_ff;
   assign acc       = req_valid && !busy_ff;
   assign wr_en     = acc && (count_ff < CW'(MAX_POINTS));
   assign wr_addr   = count_ff[CW-2:0];
   assign wr_data   = {req_coord_y, req_coord_x};
   assign job_valid = busy_ff;

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      if (acc) begin
         if (wr_en) begin
            count_in = count_ff + CW'(1);
         end
         if (req_last_point) begin
            busy_in = 1'b1;
         end
      end
      if (busy_ff && job_done) begin
         busy_in  = 1'b0;
         count_in = '0;
      end
   end

   logic [CW-1:0] job_count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         job_count_ff <= '0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         if (acc && req_last_point) begin
            job_count_ff <= count_in;
         end
      end
   end
   assign job_count = job_count_ff;
endmodule

// ===== hdl/msq_back.sv =====
// Pair search: per (i,j) not below the best area, a corner scan over k; corners checked one k per cycle.
module msq_back #(
   parameter int MAX_POINTS = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  logic [$clog2(MAX_POINTS):0]   job_count,
   output logic                          job_done,
   output logic [$clog2(MAX_POINTS)-1:0] rd_a_addr,
   input  logic [2*COORD_BITS-1:0]       rd_a_data,
   output logic [$clog2(MAX_POINTS)-1:0] rd_b_addr,
   input  logic [2*COORD_BITS-1:0]       rd_b_data,
   output logic [$clog2(MAX_POINTS)-1:0] rd_k_addr,
   input  logic [2*COORD_BITS-1:0]       rd_k_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [msq_pkg::AREA_BITS-1:0] rsp_best_area
);
   localparam int CW = $clog2(MAX_POINTS) + 1;
   localparam int AW = CW - 1;
   localparam int EW = COORD_BITS + 2;
   localparam int SW = 2 * EW;

   typedef enum logic [2:0] {S_IDLE, S_FETCH, S_PAIR, S_AREA, S_SCAN, S_OUT} state_type;
   state_type     state_ff;
   logic [CW-1:0] i_ff, j_ff, k_ff, n_ff;
   logic [SW:0]   best_ff, area_ff;
   logic signed [EW-1:0] cdx_ff, cdy_ff, ddx_ff, ddy_ff, dx_ff, dy_ff;
   logic          hitc_ff, hitd_ff, rsp_valid_ff, done_ff;
   logic [msq_pkg::AREA_BITS-1:0] out_ff;

   logic signed [EW-1:0] ax, ay, bx, by, kx, ky, dxw, dyw;
   logic [SW-1:0] sqx, sqy;
   logic [SW:0]   area_w;
   assign ax = EW'($signed(rd_a_data[COORD_BITS-1:0]));
   assign ay = EW'($signed(rd_a_data[2*COORD_BITS-1:COORD_BITS]));
   assign bx = EW'($signed(rd_b_data[COORD_BITS-1:0]));
   assign by = EW'($signed(rd_b_data[2*COORD_BITS-1:COORD_BITS]));
   assign kx = EW'($signed(rd_k_data[COORD_BITS-1:0]));
   assign ky = EW'($signed(rd_k_data[2*COORD_BITS-1:COORD_BITS]));
   assign dxw = bx - ax;
   assign dyw = by - ay;
   assign sqx = SW'(dx_ff * dx_ff);
   assign sqy = SW'(dy_ff * dy_ff);
   assign area_w = {1'b0, sqx} + {1'b0, sqy};

   assign rd_a_addr = i_ff[AW-1:0];
   assign rd_b_addr = j_ff[AW-1:0];
   assign rd_k_addr = k_ff[AW-1:0];
   assign job_done = done_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_best_area = out_ff;

   logic last_k, hc, hd;
   assign last_k = (k_ff == n_ff);
   assign hc = (kx == cdx_ff) && (ky == cdy_ff);
   assign hd = (kx == ddx_ff) && (ky == ddy_ff);

   // advance (i,j); returns done when pairs exhausted
   logic [CW-1:0] ni, nj;
   logic          pairs_end;
   always_comb begin
      ni = i_ff;
      nj = j_ff + CW'(1);
      if (nj == i_ff) begin
         nj = nj + CW'(1);
      end
      pairs_end = 1'b0;
      if (nj >= n_ff) begin
         ni = i_ff + CW'(1);
         nj = (ni == '0) ? CW'(1) : '0;
         if (ni >= n_ff) begin
            pairs_end = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
         i_ff <= '0; j_ff <= '0; k_ff <= '0; n_ff <= '0;
         best_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (job_valid && !done_ff) begin
                  n_ff    <= job_count;
                  best_ff <= '0;
                  i_ff    <= '0;
                  j_ff    <= CW'(1);
                  state_ff <= (job_count < CW'(2)) ? S_OUT : S_FETCH;
               end
            end
            S_FETCH: begin
               // (i,j) addresses are sampled by the store at the end of this cycle
               state_ff <= S_PAIR;
            end
            S_PAIR: begin
               // memory data for (i,j) valid now
               dx_ff  <= dxw;
               dy_ff  <= dyw;
               cdx_ff <= bx - dyw;
               cdy_ff <= by + dxw;
               ddx_ff <= ax - dyw;
               ddy_ff <= ay + dxw;
               k_ff   <= '0;
               state_ff <= S_AREA;
            end
            S_AREA: begin
               area_ff <= area_w;
               hitc_ff <= 1'b0;
               hitd_ff <= 1'b0;
               if (area_w < best_ff) begin
                  if (pairs_end) begin
                     state_ff <= S_OUT;
                  end else begin
                     i_ff <= ni; j_ff <= nj;
                     state_ff <= S_FETCH;
                  end
               end else begin
                  k_ff <= CW'(1);
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // rd_k_data holds entry k-1
               if ((hitc_ff || hc) && (hitd_ff || hd)) begin
                  if (area_ff > best_ff) begin
                     best_ff <= area_ff;
                  end
                  k_ff <= n_ff;
               end
               hitc_ff <= hitc_ff || hc;
               hitd_ff <= hitd_ff || hd;
               if (last_k || ((hitc_ff || hc) && (hitd_ff || hd))) begin
                  if (pairs_end) begin
                     state_ff <= S_OUT;
                  end else begin
                     i_ff <= ni; j_ff <= nj;
                     state_ff <= S_FETCH;
                  end
               end else begin
                  k_ff <= k_ff + CW'(1);
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  out_ff   <= best_ff[msq_pkg::AREA_BITS-1:0];
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done repeated");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rsp_valid_ff) else $error("done without word");
   a_best_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> best_ff >= $past(best_ff)) else $error("best fell");
`endif
endmodule

// ===== hdl/max_square_area_from_points.sv =====
// Loading: one point per cycle. From the last point to the result word, each (i,j) pair goes
// through the fetch, pair and area states, then, unless its area is below the best so far,
// a scan of one stored point per cycle. Loading stalls during a search and resumes once
// job_done has cleared the front end's busy register after the result word is issued.
// Reset: synchronous active high; clears counts and control, store is left as is.
module max_square_area_from_points #(
   parameter int MAX_POINTS = msq_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = msq_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COORD_BITS-1:0]         req_coord_x,
   input  logic [COORD_BITS-1:0]         req_coord_y,
   input  logic                          req_last_point,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [msq_pkg::AREA_BITS-1:0] rsp_best_area
);
   localparam int AW = $clog2(MAX_POINTS);
   logic          wr_en, job_valid, job_done;
   logic [AW-1:0] wr_addr, ra, rb, rk;
   logic [2*COORD_BITS-1:0] wr_data, da, db, dk;
   logic [AW:0]   job_count;

   msq_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_coord_x, .req_coord_y,
      .req_last_point, .wr_en, .wr_addr, .wr_data, .job_valid, .job_count, .job_done);

   msq_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_a (.clock, .wr_en,
      .wr_addr, .wr_data, .rd_addr(ra), .rd_data(da));
   msq_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_b (.clock, .wr_en,
      .wr_addr, .wr_data, .rd_addr(rb), .rd_data(db));
   msq_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_k (.clock, .wr_en,
      .wr_addr, .wr_data, .rd_addr(rk), .rd_data(dk));

   msq_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset, .job_valid, .job_count, .job_done,
      .rd_a_addr(ra), .rd_a_data(da), .rd_b_addr(rb), .rd_b_data(db),
      .rd_k_addr(rk), .rd_k_data(dk), .rsp_valid, .rsp_stall, .rsp_best_area);
endmodule
